/* rtl/lcdks_pkg.sv */
// ----------------------------------------------------------------------------
// lcdks_pkg
// Types and fixed constants shared by the LCD driver bank and key scan block.
// ----------------------------------------------------------------------------
package lcdks_pkg;

   // bus access kinds
   typedef enum logic [1:0] {
      ACT_PORT_WRITE = 2'd0,
      ACT_PORT_READ  = 2'd1,
      ACT_KEY_CHANGE = 2'd2,
      ACT_PIXEL_READ = 2'd3
   } action_type;

   // decoded I/O ports
   localparam logic [7:0] PORT_STROBE_A = 8'hB9;
   localparam logic [7:0] PORT_STROBE_B = 8'hBA;
   localparam logic [7:0] PORT_KEY_READ = 8'hE8;
   localparam logic [7:0] PORT_LCD_CMD  = 8'hFE;
   localparam logic [7:0] PORT_LCD_DATA = 8'hFF;

   // count direction command, bit 0 picks up or down
   localparam logic [7:0] CMD_DIR_MASK  = 8'hFE;
   localparam logic [7:0] CMD_COUNT_DIR = 8'h3A;

   // select register is always ten bits wide
   localparam int MASK_W = 10;

   // screen geometry
   localparam int SCREEN_W       = 240;
   localparam int SLOTS_PER_BAND = 5;

   // input transaction
   typedef struct packed {
      action_type  action;
      logic [7:0]  port;
      logic [7:0]  data;
      logic [3:0]  key_row;
      logic [2:0]  key_col;
      logic        key_down;
      logic [7:0]  pixel_x;
      logic [5:0]  pixel_y;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [7:0]  read_data;
      logic        handled;
      logic        pixel_on;
   } rsp_type;

endpackage

/* rtl/lcd_driver_bank_and_key_scan_top.sv */
// ----------------------------------------------------------------------------
// lcd_driver_bank_and_key_scan_top
// I/O port peripheral with a bank of LCD column drivers and a key matrix.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one bus transaction: a port write, a port read, a
// key matrix change or a pixel read. Every transaction gives exactly one rsp
// transaction with read_data, handled and pixel_on.
// A transaction is taken in every cycle when nothing stalls it. The result
// reaches rsp through the middle stage, which holds the registered read of
// the display bank, and then through the output register.
// Each driver owns one display bank RAM (columns x pages bytes), so a data
// write reaches every selected driver in the same cycle and a pixel read
// uses the read port of one bank.
// After reset all banks are swept to zero, one address per cycle in all
// banks at once, over all COLUMNS_PER_DRIVER * PAGES_PER_DRIVER addresses
// (200 with the default values). req_stall stays high during the sweep.
// When rsp_stall holds a result, one more transaction can sit in the middle
// stage; after that req_stall rises until the output register drains.
// ----------------------------------------------------------------------------
module lcd_driver_bank_and_key_scan_top
   import lcdks_pkg::*;
#(
   parameter int DRIVER_COUNT       = 10,
   parameter int COLUMNS_PER_DRIVER = 50,
   parameter int PAGES_PER_DRIVER   = 4,
   parameter int SCAN_ROWS          = 9
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int BANK_DEPTH = COLUMNS_PER_DRIVER * PAGES_PER_DRIVER;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int DRV_W      = (DRIVER_COUNT > 1) ? $clog2(DRIVER_COUNT) : 1;

   // clear sweep
   logic               clear_busy_ff, clear_busy_in;
   logic [BANK_AW-1:0] clear_addr_ff, clear_addr_in;

   // strobes and driver select
   logic [7:0]        strobe_a_ff, strobe_a_in;
   logic [7:0]        strobe_b_ff, strobe_b_in;
   logic [MASK_W-1:0] enable_mask_ff, enable_mask_in;

   // key matrix
   logic [7:0] key_rows_ff [SCAN_ROWS];
   logic [7:0] key_rows_in [SCAN_ROWS];
   logic [7:0] key_scan;

   // display banks
   logic [7:0] bank_rdata [DRIVER_COUNT];

   // middle stage
   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_read_data_ff;
   logic             s1_handled_ff;
   logic             s1_pixel_ff;
   logic             s1_pix_off_ff;
   logic [DRV_W-1:0] s1_pix_drv_ff;
   logic [2:0]       s1_pix_bit_ff;
   logic             s1_move;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // decode
   logic       accept;
   logic       is_port_wr, is_key, is_pixel;
   logic       is_cmd, is_data, is_dir_cmd;
   logic [7:0] dec_read_data;
   logic       dec_handled;

   // pixel address
   logic [2:0]       pix_slot;
   logic [8:0]       pix_col;
   logic [3:0]       pix_drv_full;
   logic             pix_off;
   logic [8:0]       pix_addr_full;
   logic [BANK_AW-1:0] pix_addr;
   logic             pix_bit_val;

   // handshake
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_busy_ff || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;

   assign is_port_wr = accept && (req_payload.action == ACT_PORT_WRITE);
   assign is_key     = accept && (req_payload.action == ACT_KEY_CHANGE);
   assign is_pixel   = accept && (req_payload.action == ACT_PIXEL_READ);
   assign is_cmd     = is_port_wr && (req_payload.port == PORT_LCD_CMD);
   assign is_data    = is_port_wr && (req_payload.port == PORT_LCD_DATA);
   assign is_dir_cmd = (req_payload.data & CMD_DIR_MASK) == CMD_COUNT_DIR;

   // clear sweep after reset
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         if (clear_addr_ff == BANK_AW'(BANK_DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end else begin
            clear_addr_in = clear_addr_ff + BANK_AW'(1);
         end
      end
   end

   // strobe and select registers
   always_comb begin
      strobe_a_in    = strobe_a_ff;
      strobe_b_in    = strobe_b_ff;
      enable_mask_in = enable_mask_ff;
      if (is_port_wr && (req_payload.port == PORT_STROBE_A)) begin
         strobe_a_in         = req_payload.data;
         enable_mask_in[7:0] = req_payload.data;
      end
      if (is_port_wr && (req_payload.port == PORT_STROBE_B)) begin
         strobe_b_in         = req_payload.data;
         enable_mask_in[9:8] = req_payload.data[1:0];
      end
   end

   // key matrix update
   always_comb begin
      for (int i = 0; i < SCAN_ROWS; i++) begin
         key_rows_in[i] = key_rows_ff[i];
         if (is_key && (req_payload.key_row == 4'(i))) begin
            key_rows_in[i][req_payload.key_col] = ~req_payload.key_down;
         end
      end
   end

   // key scan: AND of strobed rows
   always_comb begin
      key_scan = 8'hFF;
      for (int i = 0; i < SCAN_ROWS; i++) begin
         if (i < 8) begin
            if (!strobe_a_ff[i[2:0]]) begin
               key_scan = key_scan & key_rows_ff[i];
            end
         end else if (!strobe_b_ff[0]) begin
            key_scan = key_scan & key_rows_ff[i];
         end
      end
   end

   // port decode for the result
   always_comb begin
      dec_read_data = 8'h00;
      dec_handled   = 1'b0;
      case (req_payload.action)
         ACT_PORT_WRITE: begin
            dec_handled = req_payload.port inside
               {PORT_STROBE_A, PORT_STROBE_B, PORT_LCD_CMD, PORT_LCD_DATA};
         end
         ACT_PORT_READ: begin
            case (req_payload.port)
               PORT_STROBE_B: begin
                  dec_read_data = {6'd0, enable_mask_ff[9:8]};
                  dec_handled   = 1'b1;
               end
               PORT_KEY_READ: begin
                  dec_read_data = key_scan;
                  dec_handled   = 1'b1;
               end
               PORT_LCD_CMD: begin
                  dec_handled = 1'b1;
               end
               default: begin
                  dec_handled = 1'b0;
               end
            endcase
         end
         default: begin
            dec_handled = 1'b0;
         end
      endcase
   end

   // pixel to driver, column and page
   always_comb begin
      pix_slot = 3'd0;
      for (int k = 1; k <= SLOTS_PER_BAND; k++) begin
         if ({1'b0, req_payload.pixel_x} >= 9'(k * COLUMNS_PER_DRIVER)) begin
            pix_slot = 3'(k);
         end
      end
      pix_col = {1'b0, req_payload.pixel_x}
              - 9'(int'(pix_slot) * COLUMNS_PER_DRIVER);
      pix_drv_full = (req_payload.pixel_y[5] ? 4'(SLOTS_PER_BAND) : 4'd0)
                   + {1'b0, pix_slot};
      pix_off = ({1'b0, req_payload.pixel_x} >= 9'(SCREEN_W))
             || (pix_slot == 3'(SLOTS_PER_BAND))
             || (pix_drv_full >= 4'(DRIVER_COUNT))
             || ({1'b0, req_payload.pixel_y[4:3]} >= 3'(PAGES_PER_DRIVER));
      pix_addr_full = pix_col * 9'(PAGES_PER_DRIVER)
                    + {7'd0, req_payload.pixel_y[4:3]};
      pix_addr = pix_addr_full[BANK_AW-1:0];
   end

   // driver lanes: pointers and display bank
   for (genvar g = 0; g < DRIVER_COUNT; g++) begin : g_drv
      logic [1:0]         page_ff, page_in;
      logic [5:0]         column_ff, column_in;
      logic               count_down_ff, count_down_in;
      logic [6:0]         col_up, col_dn;
      logic [5:0]         col_next;
      logic               selected, in_range;
      logic [8:0]         addr_full;
      logic               bank_we, bank_re;
      logic [BANK_AW-1:0] bank_waddr;
      logic [7:0]         bank_wdata;

      assign selected = enable_mask_ff[g];
      assign col_up   = {1'b0, column_ff} + 7'd1;
      assign col_dn   = {1'b0, column_ff} - 7'd1;
      assign in_range = ({1'b0, column_ff} < 7'(COLUMNS_PER_DRIVER))
                     && ({1'b0, page_ff} < 3'(PAGES_PER_DRIVER));
      assign addr_full = {3'd0, column_ff} * 9'(PAGES_PER_DRIVER)
                       + {7'd0, page_ff};

      // column step with wrap
      always_comb begin
         if (count_down_ff) begin
            col_next = (col_dn >= 7'(COLUMNS_PER_DRIVER))
                     ? 6'(COLUMNS_PER_DRIVER - 1) : col_dn[5:0];
         end else begin
            col_next = (col_up >= 7'(COLUMNS_PER_DRIVER)) ? 6'd0 : col_up[5:0];
         end
      end

      // command and data effect on the pointers
      always_comb begin
         page_in       = page_ff;
         column_in     = column_ff;
         count_down_in = count_down_ff;
         if (is_cmd && selected) begin
            if (is_dir_cmd) begin
               count_down_in = ~req_payload.data[0];
            end else begin
               page_in   = req_payload.data[7:6];
               column_in = req_payload.data[5:0];
            end
         end else if (is_data && selected) begin
            column_in = col_next;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            page_ff       <= 2'd0;
            column_ff     <= 6'd0;
            count_down_ff <= 1'b0;
         end else begin
            page_ff       <= page_in;
            column_ff     <= column_in;
            count_down_ff <= count_down_in;
         end
      end

      // bank ports, the sweep owns the write port after reset
      assign bank_we    = clear_busy_ff || (is_data && selected && in_range);
      assign bank_waddr = clear_busy_ff ? clear_addr_ff : addr_full[BANK_AW-1:0];
      assign bank_wdata = clear_busy_ff ? 8'h00 : req_payload.data;
      assign bank_re    = is_pixel && (pix_drv_full == 4'(g));

      lcdks_ram #(
         .WIDTH (8),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we),
         .wr_addr (bank_waddr),
         .wr_data (bank_wdata),
         .rd_en   (bank_re),
         .rd_addr (pix_addr),
         .rd_data (bank_rdata[g])
      );
   end

   // bit pick from the bank that was read
   always_comb begin
      pix_bit_val = 1'b0;
      for (int i = 0; i < DRIVER_COUNT; i++) begin
         if (s1_pix_drv_ff == DRV_W'(i)) begin
            pix_bit_val = bank_rdata[i][s1_pix_bit_ff];
         end
      end
   end

   // middle stage and output register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (s1_move) begin
         rsp_valid_in     = 1'b1;
         rsp_in.read_data = s1_read_data_ff;
         rsp_in.handled   = s1_handled_ff;
         rsp_in.pixel_on  = s1_pixel_ff && !s1_pix_off_ff && pix_bit_val;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff  <= 1'b1;
         clear_addr_ff  <= '0;
         strobe_a_ff    <= 8'hFF;
         strobe_b_ff    <= 8'hFF;
         enable_mask_ff <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < SCAN_ROWS; i++) begin
            key_rows_ff[i] <= 8'hFF;
         end
      end else begin
         clear_busy_ff  <= clear_busy_in;
         clear_addr_ff  <= clear_addr_in;
         strobe_a_ff    <= strobe_a_in;
         strobe_b_ff    <= strobe_b_in;
         enable_mask_ff <= enable_mask_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         for (int i = 0; i < SCAN_ROWS; i++) begin
            key_rows_ff[i] <= key_rows_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_data_ff <= dec_read_data;
         s1_handled_ff   <= dec_handled;
         s1_pixel_ff     <= (req_payload.action == ACT_PIXEL_READ);
         s1_pix_off_ff   <= pix_off;
         s1_pix_drv_ff   <= pix_drv_full[DRV_W-1:0];
         s1_pix_bit_ff   <= req_payload.pixel_y[2:0];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   // no transaction is taken while the banks are swept
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> req_stall)
      else $error("transaction accepted during bank clear");

   // a held result keeps the middle stage occupied
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("middle stage dropped a transaction under stall");

   // a port access never reports a lit pixel
   a_pixel_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.handled) |-> !rsp_ff.pixel_on)
      else $error("pixel bit set on a port access result");
`endif

endmodule

/* rtl/lcdks_ram.sv */
// ----------------------------------------------------------------------------
// lcdks_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lcdks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 200
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/lcd_driver_bank_and_key_scan_top_tb.sv */
// ----------------------------------------------------------------------------
// lcd_driver_bank_and_key_scan_top_tb
// Drives bus transactions into the LCD driver bank and key scan block and
// checks every reply against a cycle-free model of the driver bank, the
// select register, the key strobes and the key matrix. Directed tests cover
// reset values, unhandled ports, column wrap both ways, the key scan and a
// long receiver hold; a long random phase plays driver setup, data bursts,
// pixel reads and key sequences, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module lcd_driver_bank_and_key_scan_top_tb;
   import lcdks_pkg::*;

   localparam int NUM_DRV        = 10;
   localparam int NUM_COL        = 50;
   localparam int NUM_PAGE       = 4;
   localparam int NUM_SCAN       = 9;
   localparam int LONG_HOLD      = 60;
   localparam int WATCHDOG_LIMIT = 4000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // model of the block state
   logic [7:0] glass_ram [NUM_DRV][NUM_COL][NUM_PAGE];
   logic [1:0] drv_page [NUM_DRV];
   logic [5:0] drv_col [NUM_DRV];
   logic       drv_down [NUM_DRV];
   logic [9:0] select_mask;
   logic [7:0] key_grid [NUM_SCAN];
   logic [7:0] strobe_a_q;
   logic [7:0] strobe_b_q;

   rsp_type pending_replies [$];
   rsp_type want_rsp;
   int      fail_count = 0;
   int      checked_count = 0;
   int      sent_count = 0;
   int      action_count [4] = '{0, 0, 0, 0};
   int      idle_cycles = 0;
   int      burst_left = 0;
   bit      steady_sender = 1'b0;
   logic    hold_req = 1'b0;
   int      hold_left = 0;
   int      stall_mode = 0;
   int      mode_left = 0;

   lcd_driver_bank_and_key_scan_top #(
      .DRIVER_COUNT       (NUM_DRV),
      .COLUMNS_PER_DRIVER (NUM_COL),
      .PAGES_PER_DRIVER   (NUM_PAGE),
      .SCAN_ROWS          (NUM_SCAN)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // model reset values
   task automatic clear_model();
      for (int d = 0; d < NUM_DRV; d++) begin
         for (int c = 0; c < NUM_COL; c++)
            for (int p = 0; p < NUM_PAGE; p++)
               glass_ram[d][c][p] = 8'h00;
         drv_page[d] = 2'd0;
         drv_col[d]  = 6'd0;
         drv_down[d] = 1'b0;
      end
      for (int r = 0; r < NUM_SCAN; r++)
         key_grid[r] = 8'hFF;
      select_mask = '0;
      strobe_a_q  = 8'hFF;
      strobe_b_q  = 8'hFF;
   endtask

   // apply one bus transaction to the model and return its reply
   function automatic rsp_type predict_bus_access(req_type t);
      rsp_type    r;
      logic [7:0] c;
      logic [7:0] scan;
      int         slot, drv, col, pg;
      r = '0;
      case (t.action)
         ACT_PORT_WRITE: begin
            r.handled = 1'b1;
            case (t.port)
               PORT_STROBE_A: begin
                  strobe_a_q = t.data;
                  select_mask[7:0] = t.data;
               end
               PORT_STROBE_B: begin
                  strobe_b_q = t.data;
                  select_mask[9:8] = t.data[1:0];
               end
               PORT_LCD_CMD: begin
                  for (int d = 0; d < NUM_DRV; d++) begin
                     if (select_mask[d]) begin
                        if ((t.data & CMD_DIR_MASK) == CMD_COUNT_DIR) begin
                           drv_down[d] = ~t.data[0];
                        end else begin
                           drv_page[d] = t.data[7:6];
                           drv_col[d]  = t.data[5:0];
                        end
                     end
                  end
               end
               PORT_LCD_DATA: begin
                  // store where the column is on the glass, then step with wrap
                  for (int d = 0; d < NUM_DRV; d++) begin
                     if (select_mask[d]) begin
                        c = {2'b00, drv_col[d]};
                        if (c < NUM_COL && drv_page[d] < NUM_PAGE)
                           glass_ram[d][c][drv_page[d]] = t.data;
                        c = drv_down[d] ? c - 8'd1 : c + 8'd1;
                        if (c >= NUM_COL)
                           c = drv_down[d] ? 8'(NUM_COL - 1) : 8'd0;
                        drv_col[d] = c[5:0];
                     end
                  end
               end
               default: r.handled = 1'b0;
            endcase
         end
         ACT_PORT_READ: begin
            r.handled = 1'b1;
            case (t.port)
               PORT_STROBE_B: r.read_data = {6'd0, select_mask[9:8]};
               PORT_KEY_READ: begin
                  scan = 8'hFF;
                  for (int i = 0; i < 8 && i < NUM_SCAN; i++)
                     if (!strobe_a_q[i]) scan &= key_grid[i];
                  if (NUM_SCAN > 8 && !strobe_b_q[0]) scan &= key_grid[8];
                  r.read_data = scan;
               end
               PORT_LCD_CMD: r.read_data = 8'h00;
               default: r.handled = 1'b0;
            endcase
         end
         ACT_KEY_CHANGE: begin
            if (t.key_row < NUM_SCAN)
               key_grid[t.key_row][t.key_col] = ~t.key_down;
         end
         default: begin
            // five drivers per band of 32 rows
            if (t.pixel_x < SCREEN_W) begin
               slot = int'(t.pixel_x) / NUM_COL;
               drv  = (int'(t.pixel_y) >> 5) * SLOTS_PER_BAND + slot;
               col  = int'(t.pixel_x) % NUM_COL;
               pg   = (int'(t.pixel_y) >> 3) & 3;
               if (slot < SLOTS_PER_BAND && drv < NUM_DRV && pg < NUM_PAGE)
                  r.pixel_on = glass_ram[drv][col][pg][t.pixel_y[2:0]];
            end
         end
      endcase
      return r;
   endfunction

   // transaction builders, unused fields get random content
   function automatic req_type noise_item();
      logic [63:0] bits;
      req_type     t;
      bits = {$urandom, $urandom};
      t = bits[$bits(req_type)-1:0];
      return t;
   endfunction

   function automatic req_type port_wr(logic [7:0] p, logic [7:0] d);
      req_type t;
      t = noise_item();
      t.action = ACT_PORT_WRITE;
      t.port   = p;
      t.data   = d;
      return t;
   endfunction

   function automatic req_type port_rd(logic [7:0] p);
      req_type t;
      t = noise_item();
      t.action = ACT_PORT_READ;
      t.port   = p;
      return t;
   endfunction

   function automatic req_type key_item(logic [3:0] row, logic [2:0] col, logic down);
      req_type t;
      t = noise_item();
      t.action   = ACT_KEY_CHANGE;
      t.key_row  = row;
      t.key_col  = col;
      t.key_down = down;
      return t;
   endfunction

   function automatic req_type pix_item(logic [7:0] x, logic [5:0] y);
      req_type t;
      t = noise_item();
      t.action  = ACT_PIXEL_READ;
      t.pixel_x = x;
      t.pixel_y = y;
      return t;
   endfunction

   // sender bursts and gaps
   task automatic pace_sender();
      int gap;
      if (steady_sender) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // offer one transaction and hold it until accepted
   task automatic send_item(input req_type t);
      req_valid   <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_replies.push_back(predict_bus_access(t));
      action_count[t.action]++;
      sent_count++;
      pace_sender();
   endtask

   task automatic wait_replies_drained();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // random driver setup, data burst and pixel readback
   task automatic play_display_sequence();
      int d;
      send_item(port_wr(PORT_STROBE_A, 8'($urandom)));
      if ($urandom_range(0, 2) == 0)
         send_item(port_wr(PORT_STROBE_B, 8'($urandom)));
      if ($urandom_range(0, 2) == 0)
         send_item(port_wr(PORT_LCD_CMD, {CMD_COUNT_DIR[7:1], 1'($urandom)}));
      if ($urandom_range(0, 5) == 0)
         send_item(port_wr(PORT_LCD_CMD, {2'($urandom), 6'($urandom_range(50, 63))}));
      else
         send_item(port_wr(PORT_LCD_CMD, {2'($urandom), 6'($urandom_range(0, 49))}));
      repeat ($urandom_range(1, 12))
         send_item(port_wr(PORT_LCD_DATA, 8'($urandom)));
      repeat ($urandom_range(1, 4)) begin
         d = $urandom_range(0, NUM_DRV - 1);
         send_item(pix_item(8'(NUM_COL * (d % 5) + $urandom_range(0, NUM_COL - 1)),
                            6'(32 * (d / 5) + $urandom_range(0, 31))));
      end
   endtask

   // key presses and releases followed by a strobed scan
   task automatic play_key_sequence();
      int row;
      repeat ($urandom_range(1, 4)) begin
         row = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
         send_item(key_item(4'(row), 3'($urandom), 1'($urandom)));
      end
      if ($urandom_range(0, 1) == 0)
         send_item(port_wr(PORT_STROBE_A, 8'($urandom) | 8'($urandom)));
      if ($urandom_range(0, 2) == 0)
         send_item(port_wr(PORT_STROBE_B, 8'($urandom)));
      repeat ($urandom_range(1, 2))
         send_item(port_rd(PORT_KEY_READ));
   endtask

   task automatic test_reset_values();
      send_item(port_rd(PORT_STROBE_B));
      send_item(port_rd(PORT_KEY_READ));
      send_item(port_rd(PORT_LCD_CMD));
      send_item(pix_item(8'd239, 6'd63));
   endtask

   task automatic test_unhandled_ports();
      send_item(port_wr(8'h00, 8'hFF));
      send_item(port_rd(PORT_LCD_DATA));
      send_item(port_rd(PORT_STROBE_A));
   endtask

   // all drivers selected, wrap of the column at both ends
   task automatic test_column_wrap();
      send_item(port_wr(PORT_STROBE_A, 8'hFF));
      send_item(port_wr(PORT_STROBE_B, 8'hFF));
      send_item(port_rd(PORT_STROBE_B));
      send_item(port_wr(PORT_LCD_CMD, {2'd3, 6'd49}));
      send_item(port_wr(PORT_LCD_DATA, 8'hA5));
      send_item(port_wr(PORT_LCD_DATA, 8'h5A));
      send_item(port_wr(PORT_LCD_CMD, CMD_COUNT_DIR));
      send_item(port_wr(PORT_LCD_DATA, 8'h3C));
      send_item(port_wr(PORT_LCD_DATA, 8'hC3));
      send_item(port_wr(PORT_LCD_CMD, {2'd0, 6'd63}));
      send_item(port_wr(PORT_LCD_DATA, 8'h77));
      send_item(port_wr(PORT_LCD_CMD, {CMD_COUNT_DIR[7:1], 1'b1}));
      send_item(pix_item(8'd49, 6'd31));
      send_item(pix_item(8'd200, 6'd56));
      send_item(pix_item(8'd240, 6'd0));
   endtask

   // row out of range is ignored, strobe B row joins the scan
   task automatic test_key_matrix();
      send_item(key_item(4'd0, 3'd0, 1'b1));
      send_item(key_item(4'd8, 3'd7, 1'b1));
      send_item(key_item(4'd9, 3'd5, 1'b1));
      send_item(port_wr(PORT_STROBE_A, 8'hFE));
      send_item(port_wr(PORT_STROBE_B, 8'hFE));
      send_item(port_rd(PORT_KEY_READ));
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_output_hold();
      req_valid     <= 1'b0;
      hold_req      <= 1'b1;
      steady_sender = 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (30) send_item(noise_item());
      steady_sender = 1'b0;
   endtask

   task automatic test_random_traffic(input int n_items);
      int stop_at;
      stop_at = sent_count + n_items;
      while (sent_count < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: play_display_sequence();
            4:          send_item(pix_item(8'($urandom), 6'($urandom)));
            5, 6:       play_key_sequence();
            7: begin
               case ($urandom_range(0, 3))
                  0:       send_item(port_rd(PORT_STROBE_B));
                  1:       send_item(port_rd(PORT_KEY_READ));
                  2:       send_item(port_rd(PORT_LCD_CMD));
                  default: send_item(port_rd(8'($urandom)));
               endcase
            end
            default:    send_item(noise_item());
         endcase
      end
   endtask

   // sender waits for every reply between sequences
   task automatic test_drain_pause();
      repeat (3) begin
         play_display_sequence();
         wait_replies_drained();
         play_key_sequence();
         wait_replies_drained();
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (hold_req) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ((mode_left % 5) < 2);
         endcase
      end
   end

   // reply checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (pending_replies.size() == 0) begin
            $error("reply with no transaction outstanding: %p", rsp_payload);
            fail_count++;
         end else begin
            want_rsp = pending_replies.pop_front();
            if (rsp_payload.read_data !== want_rsp.read_data) begin
               $error("read_data mismatch: expected %0h, got %0h",
                      want_rsp.read_data, rsp_payload.read_data);
               fail_count++;
            end
            if (rsp_payload.handled !== want_rsp.handled) begin
               $error("handled mismatch: expected %0b, got %0b",
                      want_rsp.handled, rsp_payload.handled);
               fail_count++;
            end
            if (rsp_payload.pixel_on !== want_rsp.pixel_on) begin
               $error("pixel_on mismatch: expected %0b, got %0b",
                      want_rsp.pixel_on, rsp_payload.pixel_on);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("lcd_driver_bank_and_key_scan_top_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_unhandled_ports();
      test_column_wrap();
      test_key_matrix();
      test_output_hold();
      test_random_traffic(1300);
      test_drain_pause();
      wait_replies_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d transactions: %0d port writes, %0d port reads,",
               sent_count, action_count[0], action_count[1]);
      $display("  %0d key changes, %0d pixel reads; %0d replies checked, %0d mismatches",
               action_count[2], action_count[3], checked_count, fail_count);
      if (fail_count == 0) begin
         $display("lcd_driver_bank_and_key_scan_top_tb passed");
      end else begin
         $display("lcd_driver_bank_and_key_scan_top_tb failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/lcdks_pkg.sv
rtl/lcdks_ram.sv
rtl/lcd_driver_bank_and_key_scan_top.sv
verif/lcd_driver_bank_and_key_scan_top_tb.sv
